[src/crsf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crsf_pkg
// Shared constants, event codes, register indexes, control structs and the
// CRC-8 byte update of the frame parser.
// ----------------------------------------------------------------------------
package crsf_pkg;

  localparam int MAX_FRAME_BYTES = 64;
  localparam int POS_W           = $clog2(MAX_FRAME_BYTES);
  localparam int NUM_CHANNELS    = 16;
  localparam int CHAN_W          = 11;
  localparam int CHAN_IDX_W      = 4;
  localparam int PACKED_BYTES    = 22;
  localparam int ACC_W           = 18;
  localparam int NBITS_W         = 5;
  localparam int FILL_W          = 5;
  localparam int KIND_W          = 3;
  localparam int CFG_IDX_W       = 3;

  localparam logic [7:0] CRC_POLY = 8'hD5;
  localparam logic [7:0] MIN_LEN  = 8'd2;
  localparam logic [7:0] MAX_LEN  = 8'(MAX_FRAME_BYTES - 2);

  localparam logic [KIND_W-1:0] EV_CHAN   = 3'd0;
  localparam logic [KIND_W-1:0] EV_ACCEPT = 3'd1;
  localparam logic [KIND_W-1:0] EV_CRC    = 3'd2;
  localparam logic [KIND_W-1:0] EV_SYNC   = 3'd3;
  localparam logic [KIND_W-1:0] EV_LEN    = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_ADDR_FLIGHT_CTRL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ADDR_CRSF_TX       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ADDR_RADIO_TX      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ADDR_RECEIVER      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS_TYPE_CODE = 3'd4;

  localparam logic [7:0] RST_ADDR_FLIGHT_CTRL   = 8'd200;
  localparam logic [7:0] RST_ADDR_CRSF_TX       = 8'd238;
  localparam logic [7:0] RST_ADDR_RADIO_TX      = 8'd234;
  localparam logic [7:0] RST_ADDR_RECEIVER      = 8'd236;
  localparam logic [7:0] RST_CHANNELS_TYPE_CODE = 8'd22;

  localparam logic [CHAN_IDX_W-1:0] LAST_CHAN = CHAN_IDX_W'(NUM_CHANNELS - 1);

  typedef struct packed {
    logic                  load_addr;
    logic                  load_len;
    logic                  body;
    logic                  emit;
    logic [KIND_W-1:0]     kind;
    logic                  last;
    logic [CHAN_IDX_W-1:0] chan_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic addr_match;
    logic len_ok;
    logic is_check;
    logic crc_ok;
    logic chan_frame;
    logic out_free;
  } dp_status_t;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

[src/crsf_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crsf_if
// Valid/ready channels of the frame parser: received bytes, events and
// configuration writes.
// ----------------------------------------------------------------------------
interface crsf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface crsf_event_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_kind;
  logic [7:0]  frame_kind;
  logic [7:0]  source_addr;
  logic [3:0]  chan_index;
  logic [10:0] chan_value;
  logic        last_of_run;
  modport source (output valid, output event_kind, output frame_kind, output source_addr,
                  output chan_index, output chan_value, output last_of_run, input ready);
  modport sink (input valid, input event_kind, input frame_kind, input source_addr,
                input chan_index, input chan_value, input last_of_run, output ready);
endinterface

interface crsf_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] reg_index;
  logic [7:0] write_data;
  modport source (output valid, output reg_index, output write_data, input ready);
  modport sink (input valid, input reg_index, input write_data, output ready);
endinterface

[src/crsf_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crsf_ctrl
// Frame state machine: hunts for a start address, takes the length, walks the
// body and sequences the channel words after a good channel frame.
// ----------------------------------------------------------------------------
module crsf_ctrl import crsf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  localparam logic [1:0] ST_HUNT = 2'd0;
  localparam logic [1:0] ST_LEN  = 2'd1;
  localparam logic [1:0] ST_BODY = 2'd2;
  localparam logic [1:0] ST_CHAN = 2'd3;

  logic [1:0]            state, state_next;
  logic [CHAN_IDX_W-1:0] cnt, cnt_next;
  logic                  accept;

  assign in_ready = (state != ST_CHAN) && status.out_free;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    cmd          = '0;
    cmd.chan_idx = cnt;
    case (state)
      ST_HUNT: begin
        if (accept) begin
          if (status.addr_match) begin
            cmd.load_addr = 1'b1;
            state_next    = ST_LEN;
          end else begin
            cmd.emit = 1'b1;
            cmd.kind = EV_SYNC;
            cmd.last = 1'b1;
          end
        end
      end
      ST_LEN: begin
        if (accept) begin
          if (status.len_ok) begin
            cmd.load_len = 1'b1;
            state_next   = ST_BODY;
          end else begin
            cmd.emit   = 1'b1;
            cmd.kind   = EV_LEN;
            cmd.last   = 1'b1;
            state_next = ST_HUNT;
          end
        end
      end
      ST_BODY: begin
        if (accept) begin
          if (status.is_check) begin
            cmd.emit   = 1'b1;
            state_next = ST_HUNT;
            if (!status.crc_ok) begin
              cmd.kind = EV_CRC;
              cmd.last = 1'b1;
            end else if (status.chan_frame) begin
              cmd.kind   = EV_ACCEPT;
              cmd.last   = 1'b0;
              cnt_next   = '0;
              state_next = ST_CHAN;
            end else begin
              cmd.kind = EV_ACCEPT;
              cmd.last = 1'b1;
            end
          end else begin
            cmd.body = 1'b1;
          end
        end
      end
      ST_CHAN: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          cmd.kind = EV_CHAN;
          cmd.last = (cnt == LAST_CHAN);
          cnt_next = cnt + 1'b1;
          if (cnt == LAST_CHAN) begin
            state_next = ST_HUNT;
          end
        end
      end
      default: begin
        state_next = ST_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_HUNT;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

[src/crsf_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crsf_dp
// Parser datapath: configuration registers, frame fields, CRC-8, channel
// unpacking into the channel store and the event output register.
// ----------------------------------------------------------------------------
module crsf_dp import crsf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [7:0]            rx_byte,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]            cfg_data,
  input  dp_cmd_t               cmd,
  output dp_status_t            status,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [KIND_W-1:0]     event_kind,
  output logic [7:0]            frame_kind,
  output logic [7:0]            source_addr,
  output logic [CHAN_IDX_W-1:0] chan_index,
  output logic [CHAN_W-1:0]     chan_value,
  output logic                  last_of_run
);

  logic [7:0]        addr_flight_ctrl, addr_crsf_tx, addr_radio_tx, addr_receiver;
  logic [7:0]        channels_type_code;
  logic [POS_W-1:0]  pos;
  logic [POS_W-1:0]  len;
  logic [7:0]        opening_addr;
  logic [7:0]        type_byte;
  logic [7:0]        crc;
  logic [ACC_W-1:0]  acc;
  logic [NBITS_W-1:0] nbits;
  logic [FILL_W-1:0] filled;
  logic [CHAN_W-1:0] store [NUM_CHANNELS];

  logic [ACC_W-1:0]   acc_merged;
  logic [NBITS_W-1:0] nbits_added;
  logic               unpack_pos;
  logic               extract;

  always_ff @(posedge clk) begin
    if (rst) begin
      addr_flight_ctrl   <= RST_ADDR_FLIGHT_CTRL;
      addr_crsf_tx       <= RST_ADDR_CRSF_TX;
      addr_radio_tx      <= RST_ADDR_RADIO_TX;
      addr_receiver      <= RST_ADDR_RECEIVER;
      channels_type_code <= RST_CHANNELS_TYPE_CODE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ADDR_FLIGHT_CTRL:   addr_flight_ctrl   <= cfg_data;
        REG_ADDR_CRSF_TX:       addr_crsf_tx       <= cfg_data;
        REG_ADDR_RADIO_TX:      addr_radio_tx      <= cfg_data;
        REG_ADDR_RECEIVER:      addr_receiver      <= cfg_data;
        REG_CHANNELS_TYPE_CODE: channels_type_code <= cfg_data;
        default: ;
      endcase
    end
  end

  assign status.addr_match = (rx_byte == addr_flight_ctrl) || (rx_byte == addr_crsf_tx) ||
                             (rx_byte == addr_radio_tx) || (rx_byte == addr_receiver);
  assign status.len_ok     = (rx_byte >= MIN_LEN) && (rx_byte <= MAX_LEN);
  assign status.is_check   = ({1'b0, pos} == ({1'b0, len} + (POS_W + 1)'(1)));
  assign status.crc_ok     = (crc == rx_byte);
  assign status.chan_frame = (type_byte == channels_type_code) &&
                             (int'(len) >= PACKED_BYTES + 2);
  assign status.out_free   = !out_valid || out_ready;

  assign acc_merged  = acc | (ACC_W'(rx_byte) << nbits);
  assign nbits_added = nbits + NBITS_W'(8);
  assign unpack_pos  = (int'(pos) >= 3) && (int'(pos) <= PACKED_BYTES + 2);
  assign extract     = (nbits_added >= NBITS_W'(CHAN_W)) &&
                       (filled < FILL_W'(NUM_CHANNELS));

  always_ff @(posedge clk) begin
    if (rst) begin
      pos          <= '0;
      len          <= '0;
      opening_addr <= '0;
      type_byte    <= '0;
      crc          <= '0;
      acc          <= '0;
      nbits        <= '0;
      filled       <= '0;
    end else if (cmd.load_addr) begin
      opening_addr <= rx_byte;
    end else if (cmd.load_len) begin
      len    <= POS_W'(rx_byte);
      pos    <= POS_W'(2);
      crc    <= '0;
      acc    <= '0;
      nbits  <= '0;
      filled <= '0;
    end else if (cmd.body) begin
      crc <= crc8_update(crc, rx_byte);
      pos <= pos + 1'b1;
      if (pos == POS_W'(2)) begin
        type_byte <= rx_byte;
      end else if (unpack_pos) begin
        if (extract) begin
          acc    <= acc_merged >> CHAN_W;
          nbits  <= nbits_added - NBITS_W'(CHAN_W);
          filled <= filled + 1'b1;
        end else begin
          acc   <= acc_merged;
          nbits <= nbits_added;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.body && (pos != POS_W'(2)) && unpack_pos && extract) begin
      store[filled[CHAN_IDX_W-1:0]] <= acc_merged[CHAN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      event_kind  <= cmd.kind;
      last_of_run <= cmd.last;
      frame_kind  <= ((cmd.kind == EV_SYNC) || (cmd.kind == EV_LEN)) ? 8'd0 : type_byte;
      source_addr <= (cmd.kind == EV_SYNC) ? 8'd0 : opening_addr;
      chan_index  <= (cmd.kind == EV_CHAN) ? cmd.chan_idx : '0;
      chan_value  <= (cmd.kind == EV_CHAN) ? store[cmd.chan_idx] : '0;
    end
  end

endmodule

[src/crsf_frame_parser_channels.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crsf_frame_parser_channels
// Byte-serial CRSF frame parser with CRC-8 check and sixteen-channel unpacking.
//
//   Channel   Direction  Carries
//   byte_in   in         rx_byte, one received byte per word
//   events    out        one event word (error, accepted frame, channel value)
//   cfg       in         reg_index and write_data of a register write
//
// A byte is taken while ready is high, which is whenever the event register is
// empty or being drained in the same cycle. A good channel frame's check byte
// starts a run of sixteen channel words, one per cycle as events drains, and
// byte_in is held off during that run. Reset is synchronous: it restores the
// default addresses and type code and returns the parser to hunting.
// Configuration writes are taken in any cycle.
// ----------------------------------------------------------------------------
module crsf_frame_parser_channels import crsf_pkg::*; (
  input logic         clk,
  input logic         rst,
  crsf_byte_if.sink   byte_in,
  crsf_event_if.source events,
  crsf_cfg_if.sink    cfg
);

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg.ready = 1'b1;

  crsf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (byte_in.valid),
    .in_ready (byte_in.ready),
    .status   (status),
    .cmd      (cmd)
  );

  crsf_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .rx_byte     (byte_in.rx_byte),
    .cfg_we      (cfg.valid),
    .cfg_index   (cfg.reg_index),
    .cfg_data    (cfg.write_data),
    .cmd         (cmd),
    .status      (status),
    .out_ready   (events.ready),
    .out_valid   (events.valid),
    .event_kind  (events.event_kind),
    .frame_kind  (events.frame_kind),
    .source_addr (events.source_addr),
    .chan_index  (events.chan_index),
    .chan_value  (events.chan_value),
    .last_of_run (events.last_of_run)
  );

  a_open_run_kind: assert property (@(posedge clk) disable iff (rst)
    events.valid && !events.last_of_run |->
      (events.event_kind == EV_ACCEPT) || (events.event_kind == EV_CHAN))
    else $error("Run left open by an event that must close it.");

  a_chan_last: assert property (@(posedge clk) disable iff (rst)
    events.valid && (events.event_kind == EV_CHAN) |->
      (events.last_of_run == (events.chan_index == LAST_CHAN)))
    else $error("Channel run not closed at the last channel.");

  a_sync_fields: assert property (@(posedge clk) disable iff (rst)
    events.valid && (events.event_kind == EV_SYNC) |->
      (events.frame_kind == 8'd0) && (events.source_addr == 8'd0))
    else $error("Sync error carries frame fields.");

  a_run_holds_input: assert property (@(posedge clk) disable iff (rst)
    events.valid && (events.event_kind == EV_CHAN) && !events.last_of_run |->
      !byte_in.ready)
    else $error("Byte taken during a channel run.");

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the CRSF frame parser. Received bytes are sent on
// the byte channel and a parser model in the bench predicts every event word.
// Each event word is compared field by field with the oldest prediction.
// Directed frames cover hunting, the length bounds, CRC errors, register
// extremes and writes made in the middle of a frame. Random traffic follows,
// made mostly of well-formed frames, with pacing changed on both sides.
// ----------------------------------------------------------------------------
module tb_top;
  import crsf_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 4;
  localparam int END_DRAIN_CYCLES = 20;
  localparam int RANDOM_BYTES_PER_PHASE = 12;

  typedef logic [7:0] octet_q_t[$];
  typedef logic [CHAN_W-1:0] chan_set_t[NUM_CHANNELS];

  typedef struct packed {
    logic [KIND_W-1:0]     kind;
    logic [7:0]            ftype;
    logic [7:0]            src;
    logic [CHAN_IDX_W-1:0] idx;
    logic [CHAN_W-1:0]     val;
    logic                  last;
  } event_word_t;

  logic clk;
  logic rst;

  crsf_byte_if  byte_ch ();
  crsf_event_if ev_ch ();
  crsf_cfg_if   cfg_ch ();

  crsf_frame_parser_channels dut (
    .clk(clk),
    .rst(rst),
    .byte_in(byte_ch),
    .events(ev_ch),
    .cfg(cfg_ch)
  );

  // Parser model state.
  logic [7:0]  addr_table[4];
  logic [7:0]  chan_type_code;
  logic [6:0]  parse_pos;
  logic [7:0]  decl_len;
  logic [7:0]  frame_src;
  logic [7:0]  frame_type;
  logic [7:0]  frame_crc;
  logic [17:0] bit_acc;
  logic [4:0]  bit_count;
  logic [4:0]  chans_done;
  logic [CHAN_W-1:0] chan_store[NUM_CHANNELS];

  event_word_t pending_events[$];
  int mismatches = 0;
  int bytes_sent = 0;
  int stall_cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] r;
    r = crc ^ b;
    repeat (8) r = r[7] ? ({r[6:0], 1'b0} ^ CRC_POLY) : {r[6:0], 1'b0};
    return r;
  endfunction

  function automatic void push_event(input logic [KIND_W-1:0] kind, input logic [7:0] ftype,
                                     input logic [7:0] src, input logic [CHAN_IDX_W-1:0] idx,
                                     input logic [CHAN_W-1:0] val, input logic last);
    event_word_t w;
    w.kind = kind;
    w.ftype = ftype;
    w.src = src;
    w.idx = idx;
    w.val = val;
    w.last = last;
    pending_events.push_back(w);
  endfunction

  function automatic void parse_rx_byte(input logic [7:0] b);
    int body_idx;
    int nbits;
    logic [31:0] wide_acc;
    if (parse_pos == 0) begin
      if (b != addr_table[0] && b != addr_table[1] && b != addr_table[2] &&
          b != addr_table[3]) begin
        push_event(EV_SYNC, 8'd0, 8'd0, '0, '0, 1'b1);
      end else begin
        frame_src = b;
        parse_pos = 7'd1;
      end
    end else if (parse_pos == 1) begin
      if (b < MIN_LEN || b > MAX_LEN) begin
        push_event(EV_LEN, 8'd0, frame_src, '0, '0, 1'b1);
        parse_pos = 7'd0;
      end else begin
        decl_len = b;
        frame_crc = 8'd0;
        bit_acc = '0;
        bit_count = '0;
        chans_done = '0;
        parse_pos = 7'd2;
      end
    end else begin
      body_idx = int'(parse_pos) - 2;
      if (body_idx + 1 >= int'(decl_len)) begin
        parse_pos = 7'd0;
        if (frame_crc != b) begin
          push_event(EV_CRC, frame_type, frame_src, '0, '0, 1'b1);
        end else if (frame_type == chan_type_code && int'(decl_len) >= PACKED_BYTES + 2) begin
          push_event(EV_ACCEPT, frame_type, frame_src, '0, '0, 1'b0);
          for (int c = 0; c < NUM_CHANNELS; c++) begin
            push_event(EV_CHAN, frame_type, frame_src, CHAN_IDX_W'(c), chan_store[c],
                       c == NUM_CHANNELS - 1);
          end
        end else begin
          push_event(EV_ACCEPT, frame_type, frame_src, '0, '0, 1'b1);
        end
      end else begin
        frame_crc = crc8_next(frame_crc, b);
        if (body_idx == 0) begin
          frame_type = b;
        end else if (body_idx - 1 < PACKED_BYTES) begin
          wide_acc = 32'(bit_acc) | (32'(b) << bit_count);
          nbits = int'(bit_count) + 8;
          while (nbits >= CHAN_W && int'(chans_done) < NUM_CHANNELS) begin
            chan_store[chans_done[3:0]] = wide_acc[CHAN_W-1:0];
            chans_done = chans_done + 5'd1;
            wide_acc = wide_acc >> CHAN_W;
            nbits = nbits - CHAN_W;
          end
          bit_acc = wide_acc[17:0];
          bit_count = 5'(nbits);
        end
        parse_pos = parse_pos + 7'd1;
      end
    end
  endfunction

  function automatic octet_q_t pack_channels(input chan_set_t vals);
    logic [NUM_CHANNELS*CHAN_W-1:0] bits;
    octet_q_t q;
    for (int c = 0; c < NUM_CHANNELS; c++) bits[c*CHAN_W +: CHAN_W] = vals[c];
    for (int i = 0; i < PACKED_BYTES; i++) q.push_back(bits[i*8 +: 8]);
    return q;
  endfunction

  function automatic chan_set_t random_channels();
    chan_set_t vals;
    int pick;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) vals[c] = '0;
      else if (pick < 30) vals[c] = '1;
      else vals[c] = CHAN_W'($urandom_range(0, 2047));
    end
    return vals;
  endfunction

  function automatic octet_q_t build_frame(input logic [7:0] src, input logic [7:0] ftype,
                                           input octet_q_t payload, input logic [7:0] crc_flip);
    octet_q_t q;
    logic [7:0] crc;
    q.push_back(src);
    q.push_back(8'(payload.size() + 2));
    q.push_back(ftype);
    crc = crc8_next(8'd0, ftype);
    foreach (payload[i]) begin
      q.push_back(payload[i]);
      crc = crc8_next(crc, payload[i]);
    end
    q.push_back(crc ^ crc_flip);
    return q;
  endfunction

  task automatic set_pace(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  task automatic wait_drained();
    byte_ch.valid <= 1'b0;
    cfg_ch.valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b);
    cfg_ch.valid <= 1'b0;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      byte_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    byte_ch.valid <= 1'b1;
    byte_ch.rx_byte <= b;
    do @(posedge clk); while (!byte_ch.ready);
    parse_rx_byte(b);
    bytes_sent++;
  endtask

  task automatic send_bytes(input octet_q_t q);
    foreach (q[i]) send_byte(q[i]);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
    wait_drained();
    cfg_ch.valid <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.write_data <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_ADDR_FLIGHT_CTRL:   addr_table[0] = data;
      REG_ADDR_CRSF_TX:       addr_table[1] = data;
      REG_ADDR_RADIO_TX:      addr_table[2] = data;
      REG_ADDR_RECEIVER:      addr_table[3] = data;
      REG_CHANNELS_TYPE_CODE: chan_type_code = data;
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    ev_ch.ready <= !rst && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : event_check
    event_word_t want;
    if (!rst && ev_ch.valid && ev_ch.ready) begin
      if (pending_events.size() == 0) begin
        $error("event word with none predicted: event_kind %0d", ev_ch.event_kind);
        mismatches++;
      end else begin
        want = pending_events.pop_front();
        check_field("event_kind", 32'(want.kind), 32'(ev_ch.event_kind));
        check_field("frame_kind", 32'(want.ftype), 32'(ev_ch.frame_kind));
        check_field("source_addr", 32'(want.src), 32'(ev_ch.source_addr));
        check_field("chan_index", 32'(want.idx), 32'(ev_ch.chan_index));
        check_field("chan_value", 32'(want.val), 32'(ev_ch.chan_value));
        check_field("last_of_run", 32'(want.last), 32'(ev_ch.last_of_run));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (byte_ch.valid && byte_ch.ready) || (ev_ch.valid && ev_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic test_sync_hunting();
    send_byte(8'h00);
    send_byte(8'hFF);
  endtask

  task automatic test_length_bounds();
    send_byte(RST_ADDR_FLIGHT_CTRL);
    send_byte(MIN_LEN - 8'd1);
    send_byte(RST_ADDR_CRSF_TX);
    send_byte(MAX_LEN + 8'd1);
    send_byte(RST_ADDR_RECEIVER);
    send_byte(8'hFF);
  endtask

  task automatic test_short_frames();
    octet_q_t no_payload;
    octet_q_t one_byte;
    one_byte.push_back(8'h00);
    send_bytes(build_frame(RST_ADDR_RADIO_TX, 8'h29, no_payload, 8'h00));
    send_bytes(build_frame(RST_ADDR_RECEIVER, RST_CHANNELS_TYPE_CODE, one_byte, 8'h01));
  endtask

  task automatic test_channel_frame_midframe_config();
    chan_set_t vals;
    octet_q_t frame;
    for (int c = 0; c < NUM_CHANNELS; c++) vals[c] = c[0] ? '1 : '0;
    frame = build_frame(RST_ADDR_FLIGHT_CTRL, 8'h5A, pack_channels(vals), 8'h00);
    for (int i = 0; i < 12; i++) send_byte(frame[i]);
    // The type code is only looked at on the check byte, the addresses only while hunting.
    cfg_write(REG_CHANNELS_TYPE_CODE, 8'h5A);
    cfg_write(REG_ADDR_FLIGHT_CTRL, 8'h11);
    for (int i = 12; i < frame.size(); i++) send_byte(frame[i]);
    send_byte(RST_ADDR_FLIGHT_CTRL);
  endtask

  task automatic test_register_extremes();
    octet_q_t no_payload;
    octet_q_t one_byte;
    one_byte.push_back(8'hFF);
    cfg_write(REG_ADDR_FLIGHT_CTRL, 8'h00);
    cfg_write(REG_ADDR_CRSF_TX, 8'hFF);
    cfg_write(REG_ADDR_RADIO_TX, 8'h80);
    cfg_write(REG_ADDR_RECEIVER, 8'h7F);
    cfg_write(REG_CHANNELS_TYPE_CODE, 8'h00);
    // Writes to indexes past the last register must change nothing.
    for (int i = int'(REG_CHANNELS_TYPE_CODE) + 1; i < (1 << CFG_IDX_W); i++) begin
      cfg_write(CFG_IDX_W'(i), 8'hFF);
    end
    send_bytes(build_frame(8'h00, 8'h00, no_payload, 8'h00));
    send_bytes(build_frame(8'hFF, 8'hFF, one_byte, 8'h00));
    send_byte(RST_ADDR_CRSF_TX);
    cfg_write(REG_CHANNELS_TYPE_CODE, 8'hFF);
  endtask

  task automatic randomize_registers();
    cfg_write(REG_ADDR_FLIGHT_CTRL, 8'($urandom));
    cfg_write(REG_ADDR_CRSF_TX, 8'($urandom));
    cfg_write(REG_ADDR_RADIO_TX, 8'($urandom));
    cfg_write(REG_ADDR_RECEIVER, 8'($urandom));
    cfg_write(REG_CHANNELS_TYPE_CODE, 8'($urandom));
  endtask

  task automatic test_random_traffic(input int byte_budget);
    int first;
    int pick;
    int cut;
    logic [7:0] src;
    logic [7:0] flip;
    logic [7:0] ftype;
    octet_q_t payload;
    octet_q_t frame;
    first = bytes_sent;
    while (bytes_sent - first < byte_budget) begin
      pick = $urandom_range(0, 99);
      src = addr_table[$urandom_range(0, 3)];
      flip = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
      payload.delete();
      if (pick < 40) begin
        payload = pack_channels(random_channels());
        repeat (($urandom_range(0, 7) == 0) ? $urandom_range(0, 38) : $urandom_range(0, 3))
          payload.push_back(8'($urandom));
        send_bytes(build_frame(src, chan_type_code, payload, flip));
      end else if (pick < 70) begin
        repeat ($urandom_range(0, 10)) payload.push_back(8'($urandom));
        ftype = ($urandom_range(0, 3) == 0) ? chan_type_code : 8'($urandom);
        send_bytes(build_frame(src, ftype, payload, flip));
      end else if (pick < 80) begin
        send_byte(src);
        send_byte(($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 1)) :
                  8'($urandom_range(int'(MAX_LEN) + 1, 255)));
      end else if (pick < 90) begin
        frame = build_frame(src, chan_type_code, pack_channels(random_channels()), 8'h00);
        cut = $urandom_range(2, frame.size() - 1);
        for (int i = 0; i < cut; i++) send_byte(frame[i]);
      end else begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      end
      if ($urandom_range(0, 7) == 0) wait_drained();
    end
  endtask

  initial begin
    rst <= 1'b1;
    byte_ch.valid <= 1'b0;
    byte_ch.rx_byte <= 8'd0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.reg_index <= '0;
    cfg_ch.write_data <= 8'd0;

    addr_table[0] = RST_ADDR_FLIGHT_CTRL;
    addr_table[1] = RST_ADDR_CRSF_TX;
    addr_table[2] = RST_ADDR_RADIO_TX;
    addr_table[3] = RST_ADDR_RECEIVER;
    chan_type_code = RST_CHANNELS_TYPE_CODE;
    parse_pos = '0;
    decl_len = '0;
    frame_src = '0;
    frame_type = '0;
    frame_crc = '0;
    bit_acc = '0;
    bit_count = '0;
    chans_done = '0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    set_pace(18, 68);
    test_sync_hunting();
    test_length_bounds();
    test_short_frames();
    test_channel_frame_midframe_config();
    test_register_extremes();

    randomize_registers();
    test_random_traffic(RANDOM_BYTES_PER_PHASE);
    set_pace(68, 18);
    randomize_registers();
    test_random_traffic(RANDOM_BYTES_PER_PHASE);
    set_pace(0, 0);
    randomize_registers();
    test_random_traffic(RANDOM_BYTES_PER_PHASE);

    wait_drained();
    repeat (END_DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
